// ===== sv/dsre_pkg.sv =====
package dsre_pkg;

  localparam int unsigned RunCap      = 280;
  localparam int unsigned CountW      = 9;
  localparam int unsigned CodeW       = 55;
  localparam int unsigned LenW        = 6;
  localparam int unsigned RunCodeW    = 20;
  localparam int unsigned RunLenW     = 5;
  localparam int unsigned EndCodeLen  = 8;

  typedef struct packed {
    logic [3:0] pixel;
    logic       line_end;
  } enc_in_t;

  typedef struct packed {
    logic [CodeW-1:0] code_bits;
    logic [LenW-1:0]  code_len;
    logic             line_done;
  } enc_out_t;

  typedef struct packed {
    logic [RunCodeW-1:0] bits;
    logic [RunLenW-1:0]  len;
  } run_code_t;

  // 4-bit/pixel code for one run, right-aligned, at most 20 bits
  function automatic run_code_t run_code(logic [3:0] c, logic [CountW-1:0] n);
    run_code_t         r;
    logic [CountW-1:0] m;
    logic [CountW-1:0] d2;
    logic [CountW-1:0] d4;
    logic [CountW-1:0] d9;
    logic [CountW-1:0] d25;
    logic [RunLenW-1:0] k;
    logic [RunCodeW-1:0] v;
    r.bits = '0;
    r.len  = '0;
    m      = n;
    // single pixel split off first for runs of one, eight, or non-zero three
    if (n == CountW'(1) || (n == CountW'(3) && c != 4'd0) || n == CountW'(8)) begin
      if (c != 4'd0) begin
        r.bits = {16'b0, c};
        r.len  = RunLenW'(4);
      end else begin
        r.bits = {12'b0, 8'b0000_1100};
        r.len  = RunLenW'(8);
      end
      m = n - CountW'(1);
    end
    d2  = m - CountW'(2);
    d4  = m - CountW'(4);
    d9  = m - CountW'(9);
    d25 = m - CountW'(25);
    k   = '0;
    v   = '0;
    if (m == CountW'(2)) begin
      k = RunLenW'(8);
      if (c != 4'd0) begin
        v = {12'b0, c, c};
      end else begin
        v = {12'b0, 8'b0000_1101};
      end
    end else if (c == 4'd0 && m >= CountW'(3) && m <= CountW'(9)) begin
      k = RunLenW'(8);
      v = {12'b0, 5'b00000, d2[2:0]};
    end else if (m > CountW'(2)) begin
      if (m <= CountW'(7)) begin
        k = RunLenW'(12);
        v = {8'b0, 4'b0000, 2'b10, d4[1:0], c};
      end else if (m <= CountW'(24)) begin
        k = RunLenW'(16);
        v = {4'b0, 8'b0000_1110, d9[3:0], c};
      end else begin
        k = RunLenW'(20);
        v = {8'b0000_1111, d25[7:0], c};
      end
    end
    r.bits = (r.bits << k) | v;
    r.len  = r.len + k;
    return r;
  endfunction

endpackage

// ===== sv/dvb_subtitle_4bit_rle_encoder_unit.sv =====
// DVB subtitle 4-bit/pixel run-length encoder
// input channel: one pixel per transfer (in_data_i.pixel), with line_end set
// on the last pixel of a line. output channel: one packed code word per
// transfer, bits right-aligned and MSB-first, code_len valid bits, line_done
// set when the word carries the end-of-string code and byte stuffing.
// a pixel that only extends the current run causes no output transfer.
// pipeline: input register, then combinational run tracking and code
// selection into the output register. one pixel per cycle is sustained
// while the receiver does not stall, set by the single code-build stage
// that updates the run state on each accepted pixel.
// when the receiver stalls the output register holds its word, one more
// pixel waits in the input register, and in_ready_o drops only when both
// are full. reset empties both registers, closes the run and clears the
// byte phase.
module dvb_subtitle_4bit_rle_encoder_unit
  import dsre_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  enc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output enc_out_t out_data_o
);

  logic              in_valid_q;
  enc_in_t           in_q;
  logic              out_valid_q;
  enc_out_t          out_q;

  logic [3:0]        run_colour_q, run_colour_d;
  logic [CountW-1:0] run_count_q, run_count_d;
  logic              run_open_q, run_open_d;
  logic [2:0]        bit_phase_q, bit_phase_d;

  logic              proc_ready;
  logic              proc_fire;
  logic              hit;
  logic              closing;
  logic [3:0]        new_colour;
  logic [CountW-1:0] new_count;
  run_code_t         close_code;
  run_code_t         flush_code;
  logic [2:0]        phase_sum;
  logic [2:0]        stuff;
  logic [RunLenW-1:0] tail_len;
  logic [CodeW-1:0]  joined;
  logic              emit;
  enc_out_t          result;

  assign proc_ready = !out_valid_q || out_ready_i;
  assign proc_fire  = in_valid_q && proc_ready;
  assign in_ready_o = !in_valid_q || proc_ready;

  always_comb begin
    hit = run_open_q && (in_q.pixel == run_colour_q)
          && (run_count_q != CountW'(RunCap));
    closing    = run_open_q && !hit;
    new_colour = hit ? run_colour_q : in_q.pixel;
    new_count  = hit ? run_count_q + CountW'(1) : CountW'(1);

    close_code = closing ? run_code(run_colour_q, run_count_q) : '0;
    flush_code = in_q.line_end ? run_code(new_colour, new_count) : '0;

    // stuffing after the end code always brings the phase back to a byte multiple
    phase_sum = bit_phase_q + close_code.len[2:0] + flush_code.len[2:0];
    stuff     = 3'd0 - phase_sum;
    tail_len  = in_q.line_end ? RunLenW'(EndCodeLen) + RunLenW'(stuff) : '0;

    joined = ({(CodeW-RunCodeW)'(0), close_code.bits} << flush_code.len)
             | {(CodeW-RunCodeW)'(0), flush_code.bits};
    result.code_bits = joined << tail_len;
    result.code_len  = LenW'(close_code.len) + LenW'(flush_code.len)
                       + LenW'(tail_len);
    result.line_done = in_q.line_end;
    emit = closing || in_q.line_end;

    if (in_q.line_end) begin
      run_open_d   = 1'b0;
      run_colour_d = 4'd0;
      run_count_d  = '0;
      bit_phase_d  = 3'd0;
    end else begin
      run_open_d   = 1'b1;
      run_colour_d = new_colour;
      run_count_d  = new_count;
      bit_phase_d  = bit_phase_q + close_code.len[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      run_open_q   <= 1'b0;
      run_colour_q <= 4'd0;
      run_count_q  <= '0;
      bit_phase_q  <= 3'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (proc_fire) begin
        run_open_q   <= run_open_d;
        run_colour_q <= run_colour_d;
        run_count_q  <= run_count_d;
        bit_phase_q  <= bit_phase_d;
      end
      if (proc_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (proc_fire && emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_run_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_count_q <= CountW'(RunCap))
    else $error("run count above cap");

  a_closed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_open_q |-> (run_count_q == '0 && run_colour_q == 4'd0))
    else $error("closed run holds stale state");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.code_len != '0)
    else $error("empty code word presented");

  a_end_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.line_done) |->
      (out_data_o.code_bits[7:0] == 8'd0 && out_data_o.code_len[2:0] == 3'd0
       || bit_phase_q != 3'd0 || out_data_o.code_bits[7:0] == 8'd0))
    else $error("line end word lacks end code");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import dsre_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  enc_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  enc_out_t out_data_o;

  // predictor state
  logic [3:0]        cur_colour;
  logic [CountW-1:0] cur_count;
  logic              run_active;
  logic [2:0]        byte_phase;
  logic [63:0]       code_acc;
  int unsigned       code_acc_len;

  enc_out_t    expected_codes[$];
  int unsigned mismatches;
  int unsigned sent_pixels;
  bit          tx_steady;
  bit          rx_steady;

  dvb_subtitle_4bit_rle_encoder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void append_bits(int unsigned n, logic [63:0] v);
    logic [63:0] mask;
    mask         = (64'd1 << n) - 64'd1;
    code_acc     = (code_acc << n) | (v & mask);
    code_acc_len = code_acc_len + n;
  endfunction

  // 4-bit/pixel code for a run of n pixels of colour c
  function automatic void emit_run_code(logic [3:0] c, int unsigned n);
    int unsigned m;
    m = n;
    // for runs of one, eight or non-zero three, one pixel goes out on its own first
    if (m == 1 || (m == 3 && c != 4'd0) || m == 8) begin
      if (c != 4'd0) begin
        append_bits(4, 64'(c));
      end else begin
        append_bits(4, 0); append_bits(2, 3); append_bits(2, 0);
      end
      m--;
    end
    if (m == 2) begin
      if (c != 4'd0) begin
        append_bits(4, 64'(c)); append_bits(4, 64'(c));
      end else begin
        append_bits(4, 0); append_bits(2, 3); append_bits(2, 1);
      end
    end else if (c == 4'd0 && m >= 3 && m <= 9) begin
      append_bits(4, 0); append_bits(1, 0); append_bits(3, 64'(m - 2));
    end else if (m > 2) begin
      append_bits(4, 0); append_bits(1, 1);
      if (m <= 7) begin
        append_bits(1, 0); append_bits(2, 64'(m - 4)); append_bits(4, 64'(c));
      end else if (m <= 24) begin
        append_bits(1, 1); append_bits(2, 2);
        append_bits(4, 64'(m - 9)); append_bits(4, 64'(c));
      end else begin
        append_bits(1, 1); append_bits(2, 3);
        append_bits(8, 64'(m - 25)); append_bits(4, 64'(c));
      end
    end
  endfunction

  // run tracking for one pixel transfer, queues the code word it causes
  function automatic void encode_pixel(logic [3:0] pix, logic last);
    logic [2:0] stuff;
    enc_out_t   word;
    code_acc     = '0;
    code_acc_len = 0;
    if (run_active && pix == cur_colour && cur_count != RunCap) begin
      cur_count++;
    end else begin
      if (run_active) emit_run_code(cur_colour, 32'(cur_count));
      cur_colour = pix;
      cur_count  = CountW'(1);
      run_active = 1'b1;
    end
    if (last) begin
      emit_run_code(cur_colour, 32'(cur_count));
      append_bits(EndCodeLen, 0);
      stuff = 3'(0 - (byte_phase + code_acc_len));
      if (stuff != 3'd0) append_bits(32'(stuff), 0);
      run_active = 1'b0;
      cur_colour = '0;
      cur_count  = '0;
      byte_phase = '0;
    end else begin
      byte_phase = 3'(byte_phase + code_acc_len);
    end
    if (code_acc_len != 0) begin
      word.code_bits = code_acc[CodeW-1:0];
      word.code_len  = LenW'(code_acc_len);
      word.line_done = last;
      expected_codes.push_back(word);
    end
  endfunction

  task automatic send_pixel(input logic [3:0] pix, input logic last);
    int unsigned gap;
    enc_in_t     item;
    gap           = tx_steady ? 0 : $urandom_range(0, 9);
    item.pixel    = pix;
    item.line_end = last;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_pixel(pix, last);
    sent_pixels++;
  endtask

  task automatic send_run(input logic [3:0] colour, input int unsigned len,
                          input logic end_line);
    for (int unsigned i = 0; i < len; i++) begin
      send_pixel(colour, end_line && (i == len - 1));
    end
  endtask

  // literal and pseudo-colour-0 codes, line end on a fresh run
  task automatic test_short_runs();
    send_run(4'd15, 1, 1'b1);
    send_run(4'd0, 1, 1'b1);
    send_run(4'd0, 2, 1'b0);
    send_run(4'd5, 2, 1'b0);
    send_run(4'd0, 3, 1'b0);
    send_run(4'd9, 3, 1'b1);
    send_run(4'd0, 1, 1'b0);
    send_run(4'd10, 1, 1'b0);
    send_run(4'd0, 2, 1'b1);
    send_run(4'd1, 1, 1'b0);
    send_run(4'd6, 1, 1'b1);
  endtask

  // zero-run form, 4-7 form, split of eight, 9-24 form edges
  task automatic test_mid_runs();
    for (int unsigned n = 3; n <= 9; n++) begin
      send_run(4'd0, n, 1'b0);
      send_run(4'(n + 6), n, 1'b0);
    end
    send_run(4'd7, 10, 1'b0);
    send_run(4'd0, 24, 1'b0);
    send_run(4'd3, 24, 1'b1);
  endtask

  // 25-280 form and the run cap
  task automatic test_long_runs();
    send_run(4'd12, 25, 1'b0);
    send_run(4'd0, 25, 1'b0);
    send_run(4'd4, 285, 1'b1);
    send_run(4'd0, 281, 1'b0);
    send_run(4'd1, 1, 1'b1);
    send_run(4'd8, 281, 1'b1);
  endtask

  task automatic test_random_lines();
    int unsigned stop_at;
    int unsigned sel;
    int unsigned len;
    logic [3:0]  colour;
    logic        end_line;
    stop_at = sent_pixels + 250;
    while (sent_pixels < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        // stray pixel, line end at random
        send_pixel(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70)      len = $urandom_range(1, 9);
        else if (sel < 92) len = $urandom_range(10, 30);
        else if (sel < 98) len = $urandom_range(31, 120);
        else               len = $urandom_range(250, 300);
        colour   = ($urandom_range(0, 9) < 3) ? 4'd0 : 4'($urandom_range(0, 15));
        end_line = ($urandom_range(0, 3) == 0);
        send_run(colour, len, end_line);
        if (end_line) begin
          if ($urandom_range(0, 3) == 0) tx_steady = !tx_steady;
          if ($urandom_range(0, 3) == 0) rx_steady = !rx_steady;
        end
      end
    end
  endtask

  // receiver: random stalls, compares each transfer with the oldest expectation
  initial begin : code_checker
    int unsigned gap;
    enc_out_t    want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
      if (expected_codes.size() == 0) begin
        $display("%0t: unexpected code word, expected none, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = expected_codes.pop_front();
        if (out_data_o.code_bits !== want.code_bits) begin
          $display("%0t: code_bits expected %h, got %h", $time, want.code_bits,
                   out_data_o.code_bits);
          mismatches++;
        end
        if (out_data_o.code_len !== want.code_len) begin
          $display("%0t: code_len expected %0d, got %0d", $time, want.code_len,
                   out_data_o.code_len);
          mismatches++;
        end
        if (out_data_o.line_done !== want.line_done) begin
          $display("%0t: line_done expected %b, got %b", $time, want.line_done,
                   out_data_o.line_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned drain;
    cur_colour   = '0;
    cur_count    = '0;
    run_active   = 1'b0;
    byte_phase   = '0;
    code_acc     = '0;
    code_acc_len = 0;
    mismatches   = 0;
    sent_pixels  = 0;
    tx_steady    = 1'b0;
    rx_steady    = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_runs();
    test_mid_runs();
    test_long_runs();
    test_random_lines();

    in_valid_i <= 1'b0;
    drain = 0;
    while (expected_codes.size() != 0 && drain < 500) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_codes.size() != 0) begin
      $display("%0t: %0d code words expected, none arrived", $time, expected_codes.size());
    end
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dsre_pkg.sv
sv/dvb_subtitle_4bit_rle_encoder_unit.sv
verif/tb_top.sv
